/* hw/rtl/one_shot_timer_bank_defines.svh */
// ----------------------------------------------------------------------------
// one_shot_timer_bank_defines.svh
// Assertion macros used by the checker file of the timer bank.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_BANK_DEFINES_SVH
`define ONE_SHOT_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OSTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define OSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ostb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostb_pkg
// Types, codes and widths shared by the one-shot timer bank.
// ----------------------------------------------------------------------------
package ostb_pkg;

  localparam int FUNC_W     = 3;
  localparam int ID_W       = 4;
  localparam int PERIOD_W   = 16;
  localparam int COUNT_W    = 16;
  localparam int TSTATE_W   = 2;
  localparam int MASK_W     = 16;

  localparam int NUM_TIMERS_DEF = 16;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESET  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd5;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [TSTATE_W-1:0] TSTATE_STOPPED = 2'd0;
  localparam logic [TSTATE_W-1:0] TSTATE_RUNNING = 2'd1;
  localparam logic [TSTATE_W-1:0] TSTATE_ABSENT  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN
  } ostb_state_t;

  typedef struct packed {
    logic elapsed;
    logic timeout;
  } ostb_mem_we_t;

endpackage

/* hw/rtl/ostb_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostb_in_if
// Request channel of the timer bank: valid, ready and one operation item.
// ----------------------------------------------------------------------------
interface ostb_in_if;
  logic                         valid;
  logic                         ready;
  logic [ostb_pkg::FUNC_W-1:0]   func;
  logic [ostb_pkg::ID_W-1:0]     timer_id;
  logic [ostb_pkg::PERIOD_W-1:0] period;
  logic                         new_state;
  logic                         handler_present;

  modport source (
    output valid, func, timer_id, period, new_state, handler_present,
    input  ready
  );

  modport sink (
    input  valid, func, timer_id, period, new_state, handler_present,
    output ready
  );
endinterface

/* hw/rtl/ostb_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostb_out_if
// Result channel of the timer bank: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface ostb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [ostb_pkg::TSTATE_W-1:0] timer_state;
  logic [ostb_pkg::MASK_W-1:0]   expired_mask;

  modport source (
    output valid, status, timer_state, expired_mask,
    input  ready
  );

  modport sink (
    input  valid, status, timer_state, expired_mask,
    output ready
  );
endinterface

/* hw/rtl/ostb_entry_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostb_entry_mem
// Elapsed-count and period memories, one write port and one registered read.
// ----------------------------------------------------------------------------
module ostb_entry_mem #(
  parameter int DEPTH = ostb_pkg::NUM_TIMERS_DEF,
  parameter int AW    = 4
) (
  input  logic                          clk,
  input  ostb_pkg::ostb_mem_we_t        we,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [ostb_pkg::COUNT_W-1:0]  elapsed_wdata,
  input  logic [ostb_pkg::PERIOD_W-1:0] timeout_wdata,
  input  logic [AW-1:0]                 rd_addr,
  output logic [ostb_pkg::COUNT_W-1:0]  elapsed_rdata,
  output logic [ostb_pkg::PERIOD_W-1:0] timeout_rdata
);
  import ostb_pkg::*;

  logic [COUNT_W-1:0]  elapsed_mem [DEPTH];
  logic [PERIOD_W-1:0] timeout_mem [DEPTH];
  logic [COUNT_W-1:0]  elapsed_rd_r;
  logic [PERIOD_W-1:0] timeout_rd_r;

  always_ff @(posedge clk) begin
    if (we.elapsed) begin
      elapsed_mem[wr_addr] <= elapsed_wdata;
    end
    if (we.timeout) begin
      timeout_mem[wr_addr] <= timeout_wdata;
    end
    elapsed_rd_r <= elapsed_mem[rd_addr];
    timeout_rd_r <= timeout_mem[rd_addr];
  end

  assign elapsed_rdata = elapsed_rd_r;
  assign timeout_rdata = timeout_rd_r;

endmodule

/* hw/rtl/one_shot_timer_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_bank
// Bank of one-shot timers: create, set state, query, delete, reset and tick.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_ch    in         valid / ready      func, timer_id, period, new_state,
//                                         handler_present
//  out_ch   out        valid / ready      status, timer_state, expired_mask
//
// Every operation but tick gives its result item in the cycle after it is
// accepted. A tick walks the count and period memories one entry per cycle
// through their single read port, and then gives its result item.
// Reset clears the present and running flags and the control state.
// The next item is taken while a result waits, as long as it leaves the
// output register in that same cycle; a stalled result holds its payload.
module one_shot_timer_bank #(
  parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF
) (
  input logic clk,
  input logic rst_n,
  ostb_in_if.sink    in_ch,
  ostb_out_if.source out_ch
);
  import ostb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  ostb_state_t state_r, state_nxt;

  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]      proc_idx_r, proc_idx_nxt;
  logic [MASK_W-1:0]     mask_r, mask_nxt;
  logic [NUM_TIMERS-1:0] present_r, present_nxt;
  logic [NUM_TIMERS-1:0] running_r, running_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_status_r, out_status_nxt;
  logic [TSTATE_W-1:0]   out_tstate_r, out_tstate_nxt;
  logic [MASK_W-1:0]     out_mask_r, out_mask_nxt;

  logic                  in_ready;
  logic                  in_fire;
  logic                  id_ok;
  logic                  live;
  logic [IDX_W-1:0]      id_idx;

  ostb_mem_we_t          mem_we;
  logic [IDX_W-1:0]      mem_wr_addr;
  logic [COUNT_W-1:0]    mem_el_wdata;
  logic [PERIOD_W-1:0]   mem_to_wdata;
  logic [COUNT_W-1:0]    rd_elapsed;
  logic [PERIOD_W-1:0]   rd_timeout;
  logic [COUNT_W-1:0]    el_inc;
  logic [MASK_W-1:0]     hit_mask;

  logic                  op_status;
  logic [TSTATE_W-1:0]   op_tstate;

  ostb_entry_mem #(
    .DEPTH (NUM_TIMERS),
    .AW    (IDX_W)
  ) u_mem (
    .clk           (clk),
    .we            (mem_we),
    .wr_addr       (mem_wr_addr),
    .elapsed_wdata (mem_el_wdata),
    .timeout_wdata (mem_to_wdata),
    .rd_addr       (cnt_r),
    .elapsed_rdata (rd_elapsed),
    .timeout_rdata (rd_timeout)
  );

  assign in_ready     = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign id_ok        = 32'(in_ch.timer_id) < NUM_TIMERS;
  assign id_idx       = IDX_W'(in_ch.timer_id);
  assign live         = id_ok && present_r[id_idx];
  assign el_inc       = rd_elapsed + COUNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.func == FUNC_TICK) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (cnt_r == IDX_W'(NUM_TIMERS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    present_nxt  = present_r;
    running_nxt  = running_r;
    mem_we       = '0;
    mem_wr_addr  = id_idx;
    mem_el_wdata = '0;
    mem_to_wdata = in_ch.period;
    op_status    = STATUS_OK;
    op_tstate    = TSTATE_STOPPED;
    hit_mask     = '0;
    cnt_nxt      = cnt_r;
    proc_vld_nxt = 1'b0;
    proc_idx_nxt = proc_idx_r;
    mask_nxt     = mask_r;

    if (in_fire) begin
      case (in_ch.func)
        FUNC_CREATE: begin
          if (id_ok) begin
            running_nxt[id_idx] = in_ch.new_state;
            present_nxt[id_idx] = in_ch.handler_present;
            mem_we.elapsed      = 1'b1;
            mem_we.timeout      = 1'b1;
          end else begin
            op_status = STATUS_FAIL;
          end
        end
        FUNC_SET: begin
          if (live) begin
            running_nxt[id_idx] = in_ch.new_state;
          end else begin
            op_status = STATUS_FAIL;
          end
        end
        FUNC_QUERY: begin
          op_tstate = live ? {1'b0, running_r[id_idx]} : TSTATE_ABSENT;
        end
        FUNC_DELETE: begin
          if (live) begin
            running_nxt[id_idx] = 1'b0;
            present_nxt[id_idx] = 1'b0;
            mem_we.elapsed      = 1'b1;
          end else begin
            op_status = STATUS_FAIL;
          end
        end
        FUNC_RESET: begin
          if (live) begin
            running_nxt[id_idx] = in_ch.new_state;
            mem_we.elapsed      = 1'b1;
          end else begin
            op_status = STATUS_FAIL;
          end
        end
        FUNC_TICK: begin
          cnt_nxt  = '0;
          mask_nxt = '0;
        end
        default: begin
          op_status = STATUS_FAIL;
          op_tstate = TSTATE_ABSENT;
        end
      endcase
    end

    if (state_r == S_SWEEP) begin
      proc_vld_nxt = 1'b1;
      proc_idx_nxt = cnt_r;
      cnt_nxt      = cnt_r + IDX_W'(1);
    end

    // The read of an entry lands in the cycle after its address; write it back now.
    if (proc_vld_r && present_r[proc_idx_r] && running_r[proc_idx_r]) begin
      mem_we.elapsed = 1'b1;
      mem_wr_addr    = proc_idx_r;
      mem_el_wdata   = el_inc;
      if (el_inc >= rd_timeout) begin
        running_nxt[proc_idx_r] = 1'b0;
        hit_mask = MASK_W'(1) << proc_idx_r;
      end
    end
    mask_nxt = mask_nxt | hit_mask;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_tstate_nxt = out_tstate_r;
    out_mask_nxt   = out_mask_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_ch.func != FUNC_TICK) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = op_status;
      out_tstate_nxt = op_tstate;
      out_mask_nxt   = '0;
    end else if (state_r == S_DRAIN) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STATUS_OK;
      out_tstate_nxt = TSTATE_STOPPED;
      out_mask_nxt   = mask_r | hit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      proc_vld_r  <= 1'b0;
      present_r   <= '0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      proc_vld_r  <= proc_vld_nxt;
      present_r   <= present_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r   <= proc_idx_nxt;
    mask_r       <= mask_nxt;
    out_status_r <= out_status_nxt;
    out_tstate_r <= out_tstate_nxt;
    out_mask_r   <= out_mask_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.timer_state  = out_tstate_r;
  assign out_ch.expired_mask = out_mask_r;

endmodule

/* hw/rtl/ostb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostb_checker
// Port-level assertions for the one-shot timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "one_shot_timer_bank_defines.svh"

module ostb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ostb_pkg::FUNC_W-1:0]   in_func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_status,
  input logic [ostb_pkg::TSTATE_W-1:0] out_timer_state,
  input logic [ostb_pkg::MASK_W-1:0]   out_expired_mask
);
  import ostb_pkg::*;

  `OSTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_timer_state) && $stable(out_expired_mask), "stalled result item changed")
  `OSTB_ASSERT_NEXT(a_op_result, in_valid && in_ready && in_func != FUNC_TICK, out_valid, "operation item gave no result in the next cycle")
  `OSTB_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_func == FUNC_TICK, !in_ready, "item taken during a tick sweep")
  `OSTB_ASSERT_SAME(a_fail_nomask, out_valid && out_status == STATUS_FAIL, out_expired_mask == '0, "failed item reports expired timers")
  `OSTB_ASSERT_SAME(a_mask_clean, out_valid && out_expired_mask != '0, out_status == STATUS_OK && out_timer_state == TSTATE_STOPPED, "tick result carries a status or state")

endmodule

bind one_shot_timer_bank ostb_checker u_ostb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_func          (in_ch.func),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_timer_state  (out_ch.timer_state),
  .out_expired_mask (out_ch.expired_mask)
);
